// ===== design/iso2ep_pkg.sv =====
// ----------------------------------------------------------------------------
// iso2ep_pkg
// Shared types, status codes and a calendar helper for the timestamp parser.
// ----------------------------------------------------------------------------
package iso2ep_pkg;

	localparam int YEAR_W  = 14;
	localparam int FIELD_W = 7;
	localparam int MILLI_W = 10;
	localparam int EPOCH_W = 49;

	localparam int REC_DEPTH = 2;
	localparam int REC_PTR_W = $clog2(REC_DEPTH);
	localparam int REC_CNT_W = $clog2(REC_DEPTH + 1);

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_SHORT = 2'd1;
	localparam logic [1:0] ST_SEP   = 2'd2;
	localparam logic [1:0] ST_CHAR  = 2'd3;

	typedef struct packed {
		logic [YEAR_W-1:0]  year;
		logic [FIELD_W-1:0] month;
		logic [FIELD_W-1:0] day;
		logic [FIELD_W-1:0] hour;
		logic [FIELD_W-1:0] minute;
		logic [FIELD_W-1:0] second;
		logic [MILLI_W-1:0] milli;
	} fields_t;

	typedef struct packed {
		fields_t    fld;
		logic [1:0] status;
		logic [7:0] term;
	} rec_t;

	// day of year counted from march 1st, for the first day of each month
	function automatic logic [8:0] doy_of_month(input logic [3:0] mon_idx);
		logic [8:0] d;
		unique case (mon_idx)
			4'd0:    d = 9'd306;
			4'd1:    d = 9'd337;
			4'd2:    d = 9'd0;
			4'd3:    d = 9'd31;
			4'd4:    d = 9'd61;
			4'd5:    d = 9'd92;
			4'd6:    d = 9'd122;
			4'd7:    d = 9'd153;
			4'd8:    d = 9'd184;
			4'd9:    d = 9'd214;
			4'd10:   d = 9'd245;
			4'd11:   d = 9'd275;
			default: d = 9'd0;
		endcase
		return d;
	endfunction

endpackage

// ===== design/iso2ep_front.sv =====
// ----------------------------------------------------------------------------
// iso2ep_front
// Byte parser: skips leading whitespace, collects the date-time fields and
// emits one record with status and terminator per timestamp.
// ----------------------------------------------------------------------------
module iso2ep_front import iso2ep_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] char_code,
	input  logic       end_of_text,
	output logic       rec_push,
	input  logic       rec_full,
	output rec_t       rec
);

	localparam logic [3:0] PH_SKIP   = 4'd0;
	localparam logic [3:0] PH_YEAR   = 4'd1;
	localparam logic [3:0] PH_MONTH  = 4'd2;
	localparam logic [3:0] PH_DAY    = 4'd3;
	localparam logic [3:0] PH_HOUR   = 4'd4;
	localparam logic [3:0] PH_MINUTE = 4'd5;
	localparam logic [3:0] PH_SECOND = 4'd6;
	localparam logic [3:0] PH_FRAC   = 4'd7;
	localparam logic [3:0] PH_ZONE   = 4'd8;
	localparam logic [3:0] PH_FAIL   = 4'd9;

	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_DASH   = 8'h2D;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_0      = 8'h30;
	localparam logic [7:0] CH_9      = 8'h39;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_T      = 8'h54;
	localparam logic [7:0] CH_Z      = 8'h5A;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_RBRACE = 8'h7D;

	localparam logic [13:0] ACC_MAX  = 14'd16383;
	localparam logic [4:0]  LEN_MAX  = 5'd31;
	localparam logic [4:0]  LEN_MIN  = 5'd10;

	logic [3:0]  phase_q;
	logic [13:0] acc_q;
	logic        fhd_q;
	fields_t     fld_q;
	logic [4:0]  len_q;
	logic [1:0]  err_q;

	logic [3:0]  ph_n;
	logic [13:0] acc_n;
	logic        fhd_n;
	fields_t     fld_n;
	logic [4:0]  len_n;
	logic [1:0]  err_n;
	logic [3:0]  sep_next;
	logic [1:0]  sep_code;
	logic [1:0]  status_n;

	logic        accepted;
	logic        is_term;
	logic        is_ws;
	logic        is_digit;
	logic        done;
	logic [17:0] acc_prod;
	logic [13:0] acc_sat;

	function automatic logic [FIELD_W-1:0] sat7(input logic [13:0] a);
		return (a > 14'd127) ? 7'd127 : a[FIELD_W-1:0];
	endfunction

	function automatic fields_t store_field(input fields_t f, input logic [3:0] p,
			input logic [13:0] a);
		fields_t r;
		r = f;
		case (p)
			PH_YEAR:   r.year   = a;
			PH_MONTH:  r.month  = sat7(a);
			PH_DAY:    r.day    = sat7(a);
			PH_HOUR:   r.hour   = sat7(a);
			PH_MINUTE: r.minute = sat7(a);
			PH_SECOND: r.second = sat7(a);
			PH_FRAC:   r.milli  = (a > 14'd1023) ? 10'd1023 : a[MILLI_W-1:0];
			default:   r = f;
		endcase
		return r;
	endfunction

	assign full     = rec_full;
	assign accepted = push & ~rec_full;

	assign is_ws    = (char_code == CH_SPACE) || (char_code == CH_TAB) ||
		(char_code == CH_LF);
	assign is_digit = (char_code >= CH_0) && (char_code <= CH_9);
	assign is_term  = ((char_code == CH_COMMA) || (char_code == CH_RPAREN) ||
		(char_code == CH_RBRACK) || (char_code == CH_RBRACE) ||
		(char_code == CH_LF)) && !((phase_q == PH_SKIP) && (char_code == CH_LF));
	assign done     = is_term | end_of_text;

	assign acc_prod = {4'd0, acc_q} * 18'd10 + {14'd0, char_code[3:0]};
	assign acc_sat  = (acc_prod > {4'd0, ACC_MAX}) ? ACC_MAX : acc_prod[13:0];

	always_comb begin
		ph_n     = phase_q;
		acc_n    = acc_q;
		fhd_n    = fhd_q;
		fld_n    = fld_q;
		len_n    = len_q;
		err_n    = err_q;
		sep_next = PH_FAIL;
		sep_code = ST_CHAR;
		status_n = ST_OK;

		if (!is_term && !((phase_q == PH_SKIP) && is_ws)) begin
			if (ph_n == PH_SKIP) begin
				ph_n = PH_YEAR;
			end
			if (len_n != LEN_MAX) begin
				len_n = len_n + 5'd1;
			end
			if (ph_n != PH_FAIL) begin
				if (is_digit) begin
					if (ph_n == PH_ZONE) begin
						ph_n  = PH_FAIL;
						err_n = ST_CHAR;
					end else begin
						acc_n = acc_sat;
						fhd_n = 1'b1;
					end
				end else if (!fhd_n) begin
					ph_n  = PH_FAIL;
					err_n = ST_CHAR;
				end else begin
					unique case (ph_n)
						PH_YEAR: begin
							if (char_code == CH_DASH) sep_next = PH_MONTH;
						end
						PH_MONTH: begin
							if (char_code == CH_DASH) sep_next = PH_DAY;
						end
						PH_DAY: begin
							if ((char_code == CH_SPACE) || (char_code == CH_T)) begin
								sep_next = PH_HOUR;
							end else begin
								sep_code = ST_SEP;
							end
						end
						PH_HOUR: begin
							if (char_code == CH_COLON) sep_next = PH_MINUTE;
						end
						PH_MINUTE: begin
							if (char_code == CH_COLON) sep_next = PH_SECOND;
							else if (char_code == CH_Z) sep_next = PH_ZONE;
						end
						PH_SECOND: begin
							if (char_code == CH_DOT) sep_next = PH_FRAC;
							else if (char_code == CH_Z) sep_next = PH_ZONE;
						end
						PH_FRAC: begin
							if (char_code == CH_Z) sep_next = PH_ZONE;
						end
						default: sep_next = PH_FAIL;
					endcase
					if (sep_next == PH_FAIL) begin
						ph_n  = PH_FAIL;
						err_n = sep_code;
					end else begin
						fld_n = store_field(fld_n, ph_n, acc_n);
						acc_n = '0;
						fhd_n = 1'b0;
						ph_n  = sep_next;
					end
				end
			end
		end

		// close the timestamp
		if (done && (ph_n != PH_FAIL) && (ph_n != PH_ZONE)) begin
			if (fhd_n && ((ph_n == PH_DAY) || (ph_n == PH_MINUTE) ||
					(ph_n == PH_SECOND) || (ph_n == PH_FRAC))) begin
				fld_n = store_field(fld_n, ph_n, acc_n);
				ph_n  = PH_ZONE;
			end else begin
				ph_n  = PH_FAIL;
				err_n = ST_CHAR;
			end
		end

		if (len_n < LEN_MIN) begin
			status_n = ST_SHORT;
		end else if (ph_n == PH_FAIL) begin
			status_n = err_n;
		end
	end

	assign rec_push   = accepted & done;
	assign rec.fld    = fld_n;
	assign rec.status = status_n;
	assign rec.term   = is_term ? char_code : 8'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SKIP;
			acc_q   <= '0;
			fhd_q   <= 1'b0;
			fld_q   <= '0;
			len_q   <= '0;
			err_q   <= ST_OK;
		end else if (accepted) begin
			if (done) begin
				phase_q <= PH_SKIP;
				acc_q   <= '0;
				fhd_q   <= 1'b0;
				fld_q   <= '0;
				len_q   <= '0;
				err_q   <= ST_OK;
			end else begin
				phase_q <= ph_n;
				acc_q   <= acc_n;
				fhd_q   <= fhd_n;
				fld_q   <= fld_n;
				len_q   <= len_n;
				err_q   <= err_n;
			end
		end
	end

endmodule

// ===== design/iso2ep_queue.sv =====
// ----------------------------------------------------------------------------
// iso2ep_queue
// Short record queue between the byte parser and the date arithmetic.
// ----------------------------------------------------------------------------
module iso2ep_queue import iso2ep_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  rec_t wdata,
	input  logic pop,
	output logic empty,
	output rec_t rdata
);

	rec_t                 entry_q [REC_DEPTH];
	logic [REC_PTR_W-1:0] wptr_q;
	logic [REC_PTR_W-1:0] rptr_q;
	logic [REC_CNT_W-1:0] count_q;
	logic                 do_push;
	logic                 do_pop;

	assign full    = (count_q == REC_CNT_W'(REC_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign rdata   = entry_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == REC_PTR_W'(REC_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == REC_PTR_W'(REC_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== design/iso2ep_back.sv =====
// ----------------------------------------------------------------------------
// iso2ep_back
// Date arithmetic sequencer: turns one parsed record into epoch milliseconds
// over six steps and holds the result in an output register.
// ----------------------------------------------------------------------------
module iso2ep_back import iso2ep_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      rec_empty,
	output logic                      rec_pop,
	input  rec_t                      rec,
	output logic                      empty,
	input  logic                      pop,
	output logic signed [EPOCH_W-1:0] epoch_ms,
	output logic [1:0]                status,
	output logic [7:0]                terminator
);

	localparam logic [2:0] BK_IDLE = 3'd0;
	localparam logic [2:0] BK_MON  = 3'd1;
	localparam logic [2:0] BK_ERA  = 3'd2;
	localparam logic [2:0] BK_YOE  = 3'd3;
	localparam logic [2:0] BK_DAYS = 3'd4;
	localparam logic [2:0] BK_SECS = 3'd5;
	localparam logic [2:0] BK_MS   = 3'd6;

	localparam logic [24:0] DAYS_BIAS = 25'd865566;

	logic [2:0] state_q;
	rec_t       job_q;

	logic signed [15:0] yc_q;
	logic [8:0]         doy_q;
	logic [14:0]        ynn_q;
	logic [5:0]         erap_q;
	logic [8:0]         yoe_q;
	logic [22:0]        erat_q;
	logic signed [24:0] days_q;
	logic signed [42:0] secs_q;

	logic                      out_valid_q;
	logic signed [EPOCH_W-1:0] epoch_q;
	logic [1:0]                status_q;
	logic [7:0]                term_q;

	// month fold
	logic [6:0]         mm1;
	logic [14:0]        q_prod;
	logic [3:0]         q_year;
	logic [6:0]         rem_w;
	logic [3:0]         mon_idx;
	logic signed [15:0] yc_c;

	// era
	logic [14:0] ynn_c;
	logic [30:0] era_prod;

	// days, seconds, milliseconds
	logic [14:0]        era400;
	logic [14:0]        yoe_w;
	logic [17:0]        yoe365;
	logic [1:0]         c100;
	logic [24:0]        days_pos;
	logic [18:0]        hms;
	logic signed [42:0] dprod;
	logic signed [52:0] ms_w;
	logic signed [EPOCH_W-1:0] ms_sat;
	logic               out_free;

	assign mm1     = job_q.fld.month - 7'd1;
	assign q_prod  = {8'd0, mm1} * 15'd171;
	assign q_year  = q_prod[14:11];
	assign rem_w   = mm1 - ({3'd0, q_year} * 7'd12);

	always_comb begin
		if (job_q.fld.month == '0) begin
			mon_idx = 4'd11;
			yc_c    = $signed({2'b00, job_q.fld.year}) - 16'sd1;
		end else begin
			mon_idx = rem_w[3:0];
			yc_c    = $signed({2'b00, job_q.fld.year}) + $signed({12'd0, q_year})
				- ((rem_w[3:0] < 4'd2) ? 16'sd1 : 16'sd0);
		end
	end

	assign ynn_c    = 15'(yc_q + 16'sd400);
	assign era_prod = {16'd0, ynn_c} * 31'd41944;

	assign era400   = {9'd0, erap_q} * 15'd400;
	assign yoe_w    = ynn_q - era400;

	assign yoe365   = {9'd0, yoe_q} * 18'd365;

	always_comb begin
		if (yoe_q >= 9'd300) c100 = 2'd3;
		else if (yoe_q >= 9'd200) c100 = 2'd2;
		else if (yoe_q >= 9'd100) c100 = 2'd1;
		else c100 = 2'd0;
	end

	assign days_pos = {2'd0, erat_q} + {7'd0, yoe365} + {18'd0, yoe_q[8:2]}
		+ {16'd0, doy_q} + {18'd0, job_q.fld.day} - {23'd0, c100};

	assign hms = ({12'd0, job_q.fld.hour} * 19'd3600)
		+ ({12'd0, job_q.fld.minute} * 19'd60) + {12'd0, job_q.fld.second};
	assign dprod = days_q * 43'sd86400;

	assign ms_w = secs_q * 53'sd1000 + $signed({43'd0, job_q.fld.milli});

	always_comb begin
		if (ms_w[52:48] == 5'b00000 || ms_w[52:48] == 5'b11111) begin
			ms_sat = ms_w[EPOCH_W-1:0];
		end else if (ms_w[52]) begin
			ms_sat = {1'b1, {(EPOCH_W-1){1'b0}}};
		end else begin
			ms_sat = {1'b0, {(EPOCH_W-1){1'b1}}};
		end
	end

	assign rec_pop  = (state_q == BK_IDLE) && !rec_empty;
	assign out_free = !out_valid_q || pop;

	always_ff @(posedge clk) begin
		unique case (state_q)
			BK_IDLE: begin
				if (rec_pop) job_q <= rec;
			end
			BK_MON: begin
				yc_q  <= yc_c;
				doy_q <= doy_of_month(mon_idx);
			end
			BK_ERA: begin
				ynn_q  <= ynn_c;
				erap_q <= era_prod[29:24];
			end
			BK_YOE: begin
				yoe_q  <= yoe_w[8:0];
				erat_q <= 23'(erap_q) * 23'd146097;
			end
			BK_DAYS: days_q <= $signed(days_pos - DAYS_BIAS);
			BK_SECS: secs_q <= dprod + $signed({24'd0, hms});
			BK_MS: begin
				if (out_free) begin
					epoch_q  <= (job_q.status == ST_OK) ? ms_sat : '0;
					status_q <= job_q.status;
					term_q   <= job_q.term;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				BK_IDLE: if (rec_pop) state_q <= BK_MON;
				BK_MON:  state_q <= BK_ERA;
				BK_ERA:  state_q <= BK_YOE;
				BK_YOE:  state_q <= BK_DAYS;
				BK_DAYS: state_q <= BK_SECS;
				BK_SECS: state_q <= BK_MS;
				BK_MS:   if (out_free) state_q <= BK_IDLE;
				default: state_q <= BK_IDLE;
			endcase
			if ((state_q == BK_MS) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign empty      = !out_valid_q;
	assign epoch_ms   = epoch_q;
	assign status     = status_q;
	assign terminator = term_q;

endmodule

// ===== design/iso8601_timestamp_to_epoch_ms_core.sv =====
// result path: the record queue, then sequencer states MON, ERA, YOE, DAYS, SECS, MS
// throughput: one byte per cycle in the parser while the record queue is not full;
// date arithmetic takes one record at a time; a two-entry record queue decouples the two
// reset: arst_n clears parser, queue and sequencer; no result is waiting after reset
// ----------------------------------------------------------------------------
// iso8601_timestamp_to_epoch_ms_core
// Parses ISO 8601 date-time text, one byte per transaction, into signed Unix
// epoch milliseconds with a status and the terminating byte.
// ----------------------------------------------------------------------------
module iso8601_timestamp_to_epoch_ms_core import iso2ep_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	output logic                      full,
	input  logic [7:0]                char_code,
	input  logic                      end_of_text,
	output logic                      empty,
	input  logic                      pop,
	output logic signed [EPOCH_W-1:0] epoch_ms,
	output logic [1:0]                status,
	output logic [7:0]                terminator
);

	logic rec_push;
	logic rec_full;
	logic rec_pop;
	logic rec_empty;
	rec_t rec_in;
	rec_t rec_out;

	iso2ep_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.char_code   (char_code),
		.end_of_text (end_of_text),
		.rec_push    (rec_push),
		.rec_full    (rec_full),
		.rec         (rec_in)
	);

	iso2ep_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (rec_push),
		.full   (rec_full),
		.wdata  (rec_in),
		.pop    (rec_pop),
		.empty  (rec_empty),
		.rdata  (rec_out)
	);

	iso2ep_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.rec_empty  (rec_empty),
		.rec_pop    (rec_pop),
		.rec        (rec_out),
		.empty      (empty),
		.pop        (pop),
		.epoch_ms   (epoch_ms),
		.status     (status),
		.terminator (terminator)
	);

	a_rec_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		rec_push |-> !rec_full)
		else $error("record pushed into a full queue");

	a_rec_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		rec_pop |-> !rec_empty)
		else $error("record taken from an empty queue");

	a_err_zero_epoch: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status != ST_OK) |-> (epoch_ms == '0))
		else $error("failed timestamp carries a non-zero epoch");

endmodule

// ===== sim/tb_iso8601_timestamp_to_epoch_ms_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_iso8601_timestamp_to_epoch_ms_core
// Streams ISO 8601 text into the parser one byte per transaction, predicts
// each timestamp's epoch, status and terminator in a local scanner, and
// checks every result in order under random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_iso8601_timestamp_to_epoch_ms_core;
	import iso2ep_pkg::*;

	localparam int unsigned CYCLE_LIMIT      = 500000;
	localparam int unsigned RANDOM_BYTES     = 1270;
	localparam int unsigned SHOWN_MISMATCHES = 10;
	localparam int unsigned SETTLE_CYCLES    = 20;
	localparam int unsigned MIN_TEXT         = 10;
	localparam logic [7:0]  CH_TAB           = 8'h09;
	localparam logic [7:0]  CH_LF            = 8'h0A;
	localparam longint      EPOCH_TOP        = (longint'(1) <<< (EPOCH_W - 1)) - 1;
	localparam longint      EPOCH_BOTTOM     = -EPOCH_TOP - 1;

	typedef enum logic [3:0] {
		SCAN_SKIP, SCAN_YEAR, SCAN_MONTH, SCAN_DAY, SCAN_HOUR,
		SCAN_MINUTE, SCAN_SECOND, SCAN_FRAC, SCAN_ZONE, SCAN_FAIL
	} scan_phase_t;

	typedef enum int unsigned {PACE_FLAT, PACE_SPARSE, PACE_BUSY} pace_t;

	typedef struct {
		logic [7:0] code;
		logic       eot;
		bit         hold;
	} text_byte_t;

	typedef struct {
		logic [EPOCH_W-1:0] ms;
		logic [1:0]         st;
		logic [7:0]         term;
	} stamp_result_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      push = 1'b0;
	logic                      full;
	logic [7:0]                char_code = 8'h00;
	logic                      end_of_text = 1'b0;
	logic                      empty;
	logic                      pop = 1'b0;
	logic signed [EPOCH_W-1:0] epoch_ms;
	logic [1:0]                status;
	logic [7:0]                terminator;

	text_byte_t    text_fifo[$];
	stamp_result_t stamps_due[$];
	bit            hold_next;

	scan_phase_t        scan_ph;
	logic [YEAR_W-1:0]  digit_acc;
	logic [YEAR_W-1:0]  year_f;
	logic [FIELD_W-1:0] month_f, day_f, hour_f, minute_f, second_f;
	logic [MILLI_W-1:0] milli_f;
	logic [4:0]         text_len;
	logic [1:0]         first_err;
	bit                 field_seen;

	int unsigned bytes_sent, stamps_checked, mismatch_count, top_hits, cycle_count;
	int unsigned status_seen [4];
	int unsigned send_gap, pop_gap;
	pace_t       send_pace, pop_pace;

	iso8601_timestamp_to_epoch_ms_core DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.char_code   (char_code),
		.end_of_text (end_of_text),
		.empty       (empty),
		.pop         (pop),
		.epoch_ms    (epoch_ms),
		.status      (status),
		.terminator  (terminator)
	);

	always #5 clk = ~clk;

	function automatic int unsigned clamp(input int unsigned v, input int unsigned top);
		return (v > top) ? top : v;
	endfunction

	function automatic longint days_to_month_start(input longint y, input longint m);
		longint era, yoe, doy, doe;
		if (m <= 2)
			y = y - 1;
		era = ((y >= 0) ? y : y - 399) / 400;
		yoe = y - era * 400;
		doy = (153 * ((m > 2) ? m - 3 : m + 9) + 2) / 5;
		doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
		return era * 146097 + doe - 719468;
	endfunction

	function automatic longint epoch_of_fields();
		longint y, m0, days, secs, ms;
		y  = longint'(year_f);
		m0 = longint'(month_f) - 1;
		if (m0 < 0) begin
			y  = y - 1;
			m0 = m0 + 12;
		end
		y    = y + m0 / 12;
		m0   = m0 % 12;
		days = days_to_month_start(y, m0 + 1) + longint'(day_f) - 1;
		secs = days * 86400 + longint'(hour_f) * 3600 + longint'(minute_f) * 60
		     + longint'(second_f);
		ms   = secs * 1000 + longint'(milli_f);
		if (ms > EPOCH_TOP)
			ms = EPOCH_TOP;
		if (ms < EPOCH_BOTTOM)
			ms = EPOCH_BOTTOM;
		return ms;
	endfunction

	task automatic clear_scan();
		scan_ph    = SCAN_SKIP;
		digit_acc  = '0;
		year_f     = '0;
		month_f    = '0;
		day_f      = '0;
		hour_f     = '0;
		minute_f   = '0;
		second_f   = '0;
		milli_f    = '0;
		text_len   = '0;
		first_err  = ST_OK;
		field_seen = 1'b0;
	endtask

	task automatic raise_error(input logic [1:0] code);
		if (scan_ph != SCAN_FAIL) begin
			first_err = code;
			scan_ph   = SCAN_FAIL;
		end
	endtask

	task automatic close_field(input scan_phase_t nxt);
		case (scan_ph)
			SCAN_YEAR:   year_f   = digit_acc;
			SCAN_MONTH:  month_f  = FIELD_W'(clamp(digit_acc, 127));
			SCAN_DAY:    day_f    = FIELD_W'(clamp(digit_acc, 127));
			SCAN_HOUR:   hour_f   = FIELD_W'(clamp(digit_acc, 127));
			SCAN_MINUTE: minute_f = FIELD_W'(clamp(digit_acc, 127));
			SCAN_SECOND: second_f = FIELD_W'(clamp(digit_acc, 127));
			SCAN_FRAC:   milli_f  = MILLI_W'(clamp(digit_acc, 1023));
			default: ;
		endcase
		digit_acc  = '0;
		field_seen = 1'b0;
		scan_ph    = nxt;
	endtask

	task automatic absorb_char(input logic [7:0] c);
		if (scan_ph == SCAN_SKIP) begin
			if (c == " " || c == CH_TAB || c == CH_LF)
				return;
			scan_ph = SCAN_YEAR;
		end
		if (text_len != 5'd31)
			text_len = text_len + 5'd1;
		if (scan_ph == SCAN_FAIL)
			return;
		if (c >= "0" && c <= "9") begin
			if (scan_ph == SCAN_ZONE) begin
				raise_error(ST_CHAR);
			end else begin
				digit_acc  = YEAR_W'(clamp(int'(digit_acc) * 10 + int'(c - "0"), 16383));
				field_seen = 1'b1;
			end
			return;
		end
		if (!field_seen) begin
			raise_error(ST_CHAR);
			return;
		end
		case (scan_ph)
			SCAN_YEAR:   if (c == "-") close_field(SCAN_MONTH); else raise_error(ST_CHAR);
			SCAN_MONTH:  if (c == "-") close_field(SCAN_DAY); else raise_error(ST_CHAR);
			SCAN_DAY:    if (c == " " || c == "T") close_field(SCAN_HOUR);
			             else raise_error(ST_SEP);
			SCAN_HOUR:   if (c == ":") close_field(SCAN_MINUTE); else raise_error(ST_CHAR);
			SCAN_MINUTE: if (c == ":") close_field(SCAN_SECOND);
			             else if (c == "Z") close_field(SCAN_ZONE);
			             else raise_error(ST_CHAR);
			SCAN_SECOND: if (c == ".") close_field(SCAN_FRAC);
			             else if (c == "Z") close_field(SCAN_ZONE);
			             else raise_error(ST_CHAR);
			SCAN_FRAC:   if (c == "Z") close_field(SCAN_ZONE); else raise_error(ST_CHAR);
			default:     raise_error(ST_CHAR);
		endcase
	endtask

	task automatic predict_byte(input logic [7:0] c, input logic eot);
		bit            is_term;
		stamp_result_t r;
		longint        ms;
		is_term = (c == "," || c == ")" || c == "]" || c == "}" || c == CH_LF)
		       && !(scan_ph == SCAN_SKIP && c == CH_LF);
		if (!is_term)
			absorb_char(c);
		if (!is_term && !eot)
			return;
		if (scan_ph != SCAN_FAIL && scan_ph != SCAN_ZONE) begin
			if (field_seen && (scan_ph == SCAN_DAY || scan_ph == SCAN_MINUTE ||
			    scan_ph == SCAN_SECOND || scan_ph == SCAN_FRAC))
				close_field(SCAN_ZONE);
			else
				raise_error(ST_CHAR);
		end
		if (text_len < MIN_TEXT)
			r.st = ST_SHORT;
		else if (scan_ph == SCAN_FAIL)
			r.st = first_err;
		else
			r.st = ST_OK;
		ms     = (r.st == ST_OK) ? epoch_of_fields() : 64'sd0;
		r.ms   = ms[EPOCH_W-1:0];
		r.term = is_term ? c : 8'h00;
		stamps_due = {stamps_due, r};
		status_seen[r.st]++;
		if (ms == EPOCH_TOP)
			top_hits++;
		clear_scan();
	endtask

	function automatic int unsigned draw_wait(input pace_t pace);
		case (pace)
			PACE_FLAT:   return 0;
			PACE_SPARSE: return ($urandom_range(0, 4) == 0) ? $urandom_range(1, 16) : 0;
			default:     return $urandom_range(0, 16);
		endcase
	endfunction

	function automatic logic [7:0] pick_from(input string set);
		return set[$urandom_range(0, set.len() - 1)];
	endfunction

	function automatic string two_digits(input int unsigned lo, input int unsigned hi);
		int unsigned v;
		v = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 99) : $urandom_range(lo, hi);
		return ($urandom_range(0, 7) == 0) ? $sformatf("%0d", v) : $sformatf("%02d", v);
	endfunction

	function automatic string compose_stamp();
		string       s;
		int unsigned n_blank;
		s       = "";
		n_blank = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
		repeat (n_blank)
			s = $sformatf("%s%c", s, pick_from(" \t\n"));
		case ($urandom_range(0, 9))
			0:       s = $sformatf("%s%04d", s, $urandom_range(0, 9999));
			1:       s = $sformatf("%s%0d", s, $urandom_range(10000, 99999));
			default: s = $sformatf("%s%04d", s, $urandom_range(1900, 2150));
		endcase
		s = {s, "-", two_digits(1, 12), "-", two_digits(1, 31)};
		if ($urandom_range(0, 3) != 0) begin
			s = $sformatf("%s%c%s:%s", s, pick_from(" T"), two_digits(0, 23),
			              two_digits(0, 59));
			if ($urandom_range(0, 2) != 0) begin
				s = {s, ":", two_digits(0, 59)};
				if ($urandom_range(0, 1) != 0) begin
					s = {s, "."};
					repeat ($urandom_range(1, 5))
						s = $sformatf("%s%0d", s, $urandom_range(0, 9));
				end
			end
			if ($urandom_range(0, 1) != 0)
				s = {s, "Z"};
		end
		return s;
	endfunction

	function automatic string mangle(input string s);
		int unsigned p;
		logic [7:0]  ch;
		p  = $urandom_range(0, s.len() - 1);
		ch = ($urandom_range(0, 1) == 0) ? pick_from("-:TZ. +/x5") : 8'($urandom_range(1, 255));
		case ($urandom_range(0, 2))
			0:       s.putc(p, ch);
			1:       s = s.substr(0, p);
			default: s = $sformatf("%s%c%s", s.substr(0, p), ch, s.substr(p + 1, s.len() - 1));
		endcase
		return s;
	endfunction

	task automatic queue_text(input string s, input bit eot_last);
		text_byte_t b;
		for (int i = 0; i < s.len(); i++) begin
			b.code = s[i];
			b.eot  = eot_last && (i == s.len() - 1);
			b.hold = hold_next && (i == 0);
			text_fifo = {text_fifo, b};
		end
		hold_next = 1'b0;
	endtask

	task automatic queue_stamp(input string s);
		if ($urandom_range(0, 3) == 0)
			queue_text(s, 1'b1);
		else
			queue_text($sformatf("%s%c", s, pick_from(",)]}\n")), $urandom_range(0, 3) == 0);
	endtask

	task automatic queue_noise();
		text_byte_t  b;
		int unsigned n;
		n = $urandom_range(1, 24);
		for (int i = 0; i < n; i++) begin
			b.code = 8'($urandom_range(0, 255));
			b.eot  = (i == n - 1);
			b.hold = hold_next && (i == 0);
			text_fifo = {text_fifo, b};
		end
		hold_next = 1'b0;
	endtask

	task automatic note_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= SHOWN_MISMATCHES)
			$display("mismatch at %0t: %s", $time, what);
	endtask

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push        <= 1'b0;
			char_code   <= 8'h00;
			end_of_text <= 1'b0;
			send_gap = 0;
		end else begin
			if (push && !full) begin
				predict_byte(char_code, end_of_text);
				bytes_sent++;
				send_gap = draw_wait(send_pace);
				if ($urandom_range(0, 39) == 0)
					send_pace = pace_t'($urandom_range(0, 2));
			end
			if (!(push && full)) begin
				if (send_gap != 0) begin
					send_gap--;
					push <= 1'b0;
				end else if (text_fifo.size() == 0 ||
				             (text_fifo[0].hold && stamps_due.size() != 0)) begin
					push <= 1'b0;
				end else begin
					push        <= 1'b1;
					char_code   <= text_fifo[0].code;
					end_of_text <= text_fifo[0].eot;
					void'(text_fifo.pop_front());
				end
			end
		end
	end

	// receiver and checker
	always @(posedge clk or negedge arst_n) begin
		stamp_result_t want;
		if (!arst_n) begin
			pop <= 1'b0;
			pop_gap = 0;
		end else begin
			if (pop && !empty) begin
				if (stamps_due.size() == 0) begin
					note_mismatch($sformatf("unexpected transaction epoch %0d status %0d term %02h",
					              epoch_ms, status, terminator));
				end else begin
					want = stamps_due.pop_front();
					if (epoch_ms !== want.ms)
						note_mismatch($sformatf("epoch_ms expected %0d got %0d",
						              $signed(want.ms), epoch_ms));
					if (status !== want.st)
						note_mismatch($sformatf("status expected %0d got %0d", want.st, status));
					if (terminator !== want.term)
						note_mismatch($sformatf("terminator expected %02h got %02h",
						              want.term, terminator));
				end
				stamps_checked++;
				pop_gap = draw_wait(pop_pace);
				if ($urandom_range(0, 29) == 0)
					pop_pace = pace_t'($urandom_range(0, 2));
			end
			if (pop_gap != 0) begin
				pop_gap--;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		int unsigned base;
		bit          mid_held;
		clear_scan();
		send_pace = PACE_FLAT;
		pop_pace  = PACE_FLAT;
		mid_held  = 1'b0;

		queue_text("1970-01-01,", 1'b0);
		queue_text("1234-12-12T12:12:12Z", 1'b1);
		queue_text(" \t\n2024-02-29 23:59:59.999Z)", 1'b0);
		queue_text("2000-03-01T00:00]", 1'b0);
		queue_text("0000-00-00}", 1'b0);
		queue_text("99999-127-127T127:127:127.99999Z\n", 1'b0);
		queue_text("1970-1-1,", 1'b0);
		queue_text(",", 1'b0);
		queue_text("\t", 1'b1);
		queue_text("2020-01-01X12:00,", 1'b0);
		queue_text("2020-01-01Z,", 1'b0);
		queue_text("2020-01-01T12,", 1'b0);
		queue_text("2020-01-01T12:30:,", 1'b0);
		queue_text("2020-01-01T", 1'b1);
		queue_text("2020-01-01T12:30Z5,", 1'b0);
		queue_text("-2020-01-01,", 1'b0);
		queue_text("2020--01-01T00:00,", 1'b0);
		queue_text("2020-01-01 12:30.5,", 1'b0);
		queue_text("20200101T12:00:00,", 1'b0);
		queue_text("2020/01/01 and more text here)", 1'b0);
		queue_text("ab,", 1'b0);
		queue_text("2020-13-01 00:00,", 1'b0);
		queue_text("2021-06-15T10:20:30.5Z", 1'b1);
		queue_text("2021-06-15T10:20:30.123", 1'b1);
		queue_text("2021-06-15T10:20:45,", 1'b1);
		queue_text("\n\n2021-06-15 10:20:45.007Z\n", 1'b0);

		// mostly well formed stamps, the rest mangled stamps and raw bytes
		base      = text_fifo.size();
		hold_next = 1'b1;
		while (text_fifo.size() < base + RANDOM_BYTES) begin
			if (!mid_held && text_fifo.size() > base + RANDOM_BYTES / 2) begin
				hold_next = 1'b1;
				mid_held  = 1'b1;
			end
			case ($urandom_range(0, 19))
				0, 1, 2: queue_noise();
				3, 4, 5: queue_stamp(mangle(compose_stamp()));
				default: queue_stamp(compose_stamp());
			endcase
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		while (text_fifo.size() != 0 || push)
			@(negedge clk);
		while (stamps_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);

		$display("%0d text bytes sent, %0d timestamps checked: %0d valid, %0d too short,",
		         bytes_sent, stamps_checked, status_seen[ST_OK], status_seen[ST_SHORT]);
		$display("%0d bad separator, %0d bad character, %0d clamped epochs, %0d mismatches",
		         status_seen[ST_SEP], status_seen[ST_CHAR], top_hits, mismatch_count);
		if (mismatch_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
